@@ hw/rtl/tpvr_pkg.sv @@
`timescale 1ns / 1ps

package tpvr_pkg;

  // Request codes
  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_SELECT = 2'd2,
    FUNC_FETCH  = 2'd3
  } func_t;

  localparam int OFF_W    = 13;
  localparam int BYTE_W   = 8;
  localparam int PIX_CNT  = 8;
  localparam int PAL_W    = 64;

  // Palette byte bit positions
  localparam int PAL_RED   = 2;
  localparam int PAL_GREEN = 5;
  localparam int PAL_BLUE  = 6;

  // Plane select value that clears all planes on write and reads as zero
  localparam logic [1:0] SEL_CLEAR = 2'd3;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [OFF_W-1:0]  offset_t;

endpackage

@@ hw/rtl/three_plane_video_ram_scanout_top.sv @@
`timescale 1ns / 1ps
// Sequence: an accepted request enters REDUCE, which subtracts PLANE_DEPTH from the
//   offset once per cycle until it drops below the depth (no subtraction at depth >= 8192);
//   writes and selects finish there, reads and fetches go on through LOAD (fetches then EMIT).
// A new request is taken only once the last one is done and busy has fallen.
// Pixels leave one per cycle from a shift register fed by one registered plane read.
// The receiver cannot stall. Synchronous reset clears the sequencer, select and palette.
module three_plane_video_ram_scanout_top
  import tpvr_pkg::*;
#(
  parameter int PLANE_DEPTH = 8192
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        func,
  input  logic [OFF_W-1:0]  vram_offset,
  input  logic [BYTE_W-1:0] write_byte,
  input  logic              select_bit_index,
  input  logic              palette_valid,
  output logic              palette_ready,
  input  logic [PAL_W-1:0]  palette_prom_bytes,
  output logic              strobe,
  output logic [BYTE_W-1:0] read_byte,
  output logic [7:0]        pixel_x,
  output logic [7:0]        pixel_y,
  output logic [2:0]        color_index,
  output logic              red_on,
  output logic              green_on,
  output logic              blue_on,
  output logic              is_pixel,
  output logic              last_pixel
);

  localparam int          AW      = $clog2(PLANE_DEPTH);
  localparam logic [31:0] DEPTH32 = PLANE_DEPTH;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_REDUCE = 2'd1;
  localparam logic [1:0] S_LOAD   = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]        state;
  func_t             func_q;
  offset_t           off;
  byte_t             wdata;
  logic              bitsel;
  logic [1:0]        plane_select;
  logic [PAL_W-1:0]  palette;
  byte_t             sh0, sh1, sh2;
  logic [2:0]        cnt;

  byte_t plane0 [PLANE_DEPTH];
  byte_t plane1 [PLANE_DEPTH];
  byte_t plane2 [PLANE_DEPTH];
  byte_t rd0, rd1, rd2;

  logic              wrapped;
  logic [AW-1:0]     addr;
  logic              do_write;
  logic              we0, we1, we2;
  byte_t             wval;
  logic [2:0]        color;
  byte_t             pal_byte;

  assign busy          = (state != S_IDLE);
  assign palette_ready = !busy;

  // offset is final once it drops below the depth
  assign wrapped  = ({19'd0, off} < DEPTH32);
  assign addr     = AW'(off);
  assign do_write = (state == S_REDUCE) && wrapped && (func_q == FUNC_WRITE);
  assign we0      = do_write && ((plane_select == 2'd0) || (plane_select == SEL_CLEAR));
  assign we1      = do_write && ((plane_select == 2'd1) || (plane_select == SEL_CLEAR));
  assign we2      = do_write && ((plane_select == 2'd2) || (plane_select == SEL_CLEAR));
  assign wval     = (plane_select == SEL_CLEAR) ? '0 : wdata;

  assign color    = {sh0[BYTE_W-1], sh1[BYTE_W-1], sh2[BYTE_W-1]};
  assign pal_byte = palette[{color, 3'b000} +: BYTE_W];

  always_ff @(posedge clk) begin
    if (we0) plane0[addr] <= wval;
    if (we1) plane1[addr] <= wval;
    if (we2) plane2[addr] <= wval;
    rd0 <= plane0[addr];
    rd1 <= plane1[addr];
    rd2 <= plane2[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      palette <= '0;
    end else if (palette_valid && palette_ready) begin
      palette <= palette_prom_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      plane_select <= '0;
      strobe       <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            func_q <= func_t'(func);
            off    <= vram_offset;
            wdata  <= write_byte;
            bitsel <= select_bit_index;
            state  <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (!wrapped) begin
            off <= off - OFF_W'(PLANE_DEPTH);
          end else begin
            case (func_q) inside
              FUNC_SELECT: begin
                if (bitsel) plane_select[1] <= wdata[0];
                else        plane_select[0] <= wdata[0];
                state <= S_IDLE;
              end
              FUNC_READ, FUNC_FETCH: state <= S_LOAD;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LOAD: begin
          if (func_q == FUNC_READ) begin
            strobe      <= 1'b1;
            is_pixel    <= 1'b0;
            last_pixel  <= 1'b1;
            pixel_x     <= '0;
            pixel_y     <= '0;
            color_index <= '0;
            red_on      <= 1'b0;
            green_on    <= 1'b0;
            blue_on     <= 1'b0;
            unique case (plane_select)
              2'd0:    read_byte <= rd0;
              2'd1:    read_byte <= rd1;
              2'd2:    read_byte <= rd2;
              default: read_byte <= '0;
            endcase
            state <= S_IDLE;
          end else begin
            sh0   <= rd0;
            sh1   <= rd1;
            sh2   <= rd2;
            cnt   <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          strobe      <= 1'b1;
          is_pixel    <= 1'b1;
          last_pixel  <= (cnt == 3'd7);
          read_byte   <= '0;
          pixel_x     <= {off[4:0], cnt};
          pixel_y     <= off[12:5];
          color_index <= color;
          red_on      <= pal_byte[PAL_RED];
          green_on    <= pal_byte[PAL_GREEN];
          blue_on     <= pal_byte[PAL_BLUE];
          sh0         <= {sh0[BYTE_W-2:0], 1'b0};
          sh1         <= {sh1[BYTE_W-2:0], 1'b0};
          sh2         <= {sh2[BYTE_W-2:0], 1'b0};
          cnt         <= cnt + 3'd1;
          if (cnt == 3'd7) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/tpvr_checker.sv @@
`timescale 1ns / 1ps

module tpvr_checker
  import tpvr_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              strobe,
  input logic [BYTE_W-1:0] read_byte,
  input logic [7:0]        pixel_x,
  input logic [7:0]        pixel_y,
  input logic [2:0]        color_index,
  input logic              is_pixel,
  input logic              last_pixel
);

  // an accepted request always raises busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || $past(rst))
    else $error("not busy after accepted request");

  // the eight pixels of a fetch come back to back
  a_pixels_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && is_pixel && !last_pixel |=> (strobe && is_pixel) || $past(rst))
    else $error("gap inside pixel burst");

  a_pixel_x_steps: assert property (@(posedge clk) disable iff (rst)
    strobe && is_pixel && !last_pixel |=>
      (pixel_x == 8'($past(pixel_x) + 8'd1) && $stable(pixel_y)) || $past(rst))
    else $error("pixel position not stepping");

  // a read result is a single item with zeroed pixel fields
  a_read_shape: assert property (@(posedge clk) disable iff (rst)
    strobe && !is_pixel |-> last_pixel && pixel_x == 8'd0 && color_index == 3'd0)
    else $error("malformed read result");

  a_pixel_no_read_data: assert property (@(posedge clk) disable iff (rst)
    strobe && is_pixel |-> read_byte == '0)
    else $error("read data in pixel result");

endmodule

bind three_plane_video_ram_scanout_top tpvr_checker u_tpvr_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import tpvr_pkg::*;

  localparam int DEPTH = 8192;

  typedef struct {
    func_t   op;
    offset_t off;
    byte_t   data;
    logic    idx;
  } vram_req_t;

  typedef struct {
    byte_t      read_byte;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [2:0] color_index;
    logic       red_on;
    logic       green_on;
    logic       blue_on;
    logic       is_pixel;
    logic       last_pixel;
  } scan_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  func_t             func = FUNC_WRITE;
  offset_t           vram_offset = '0;
  byte_t             write_byte = '0;
  logic              select_bit_index = 1'b0;
  logic              palette_valid = 1'b0;
  logic              palette_ready;
  logic [PAL_W-1:0]  palette_prom_bytes = '0;
  logic              strobe;
  byte_t             read_byte;
  logic [7:0]        pixel_x;
  logic [7:0]        pixel_y;
  logic [2:0]        color_index;
  logic              red_on;
  logic              green_on;
  logic              blue_on;
  logic              is_pixel;
  logic              last_pixel;

  three_plane_video_ram_scanout_top u_dut (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .func               (func),
    .vram_offset        (vram_offset),
    .write_byte         (write_byte),
    .select_bit_index   (select_bit_index),
    .palette_valid      (palette_valid),
    .palette_ready      (palette_ready),
    .palette_prom_bytes (palette_prom_bytes),
    .strobe             (strobe),
    .read_byte          (read_byte),
    .pixel_x            (pixel_x),
    .pixel_y            (pixel_y),
    .color_index        (color_index),
    .red_on             (red_on),
    .green_on           (green_on),
    .blue_on            (blue_on),
    .is_pixel           (is_pixel),
    .last_pixel         (last_pixel)
  );

  initial forever #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  vram_req_t    req_q[$];
  scan_result_t scan_expect_q[$];
  int           errors = 0;

  // Predictor copy of the block state, updated at request acceptance
  byte_t            plane_copy [3][DEPTH];
  logic [1:0]       sel_copy = 2'd0;
  logic [PAL_W-1:0] cur_palette = '0;

  // Generator bookkeeping: which plane bytes hold known data
  logic [2:0] wr_mark [DEPTH];
  int         wr_list[$];
  int         fetch_ok[$];
  int         hot_offs[16];
  logic [1:0] gen_sel = 2'd0;

  task automatic predict_request(input vram_req_t rq);
    scan_result_t r;
    logic [2:0]   col;
    byte_t        pal;
    int           i;
    r = '{default: '0};
    case (rq.op)
      FUNC_WRITE: begin
        if (sel_copy == SEL_CLEAR) begin
          for (i = 0; i < 3; i++) plane_copy[i][rq.off] = '0;
        end else begin
          plane_copy[sel_copy][rq.off] = rq.data;
        end
      end
      FUNC_SELECT: begin
        sel_copy[rq.idx] = rq.data[0];
      end
      FUNC_READ: begin
        if (sel_copy != SEL_CLEAR) r.read_byte = plane_copy[sel_copy][rq.off];
        r.last_pixel = 1'b1;
        scan_expect_q.push_back(r);
      end
      default: begin
        for (i = 0; i < PIX_CNT; i++) begin
          col = {plane_copy[0][rq.off][7-i], plane_copy[1][rq.off][7-i],
                 plane_copy[2][rq.off][7-i]};
          pal = cur_palette[col*8 +: 8];
          r.pixel_x     = {rq.off[4:0], i[2:0]};
          r.pixel_y     = rq.off[12:5];
          r.color_index = col;
          r.red_on      = pal[PAL_RED];
          r.green_on    = pal[PAL_GREEN];
          r.blue_on     = pal[PAL_BLUE];
          r.is_pixel    = 1'b1;
          r.last_pixel  = (i == PIX_CNT - 1);
          scan_expect_q.push_back(r);
        end
      end
    endcase
  endtask

  // Driver: bursts of requests with random gaps
  int burst_left = 0;
  int gap_left = 0;
  vram_req_t next_req;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      burst_left = $urandom_range(1, 16);
      gap_left = 0;
    end else begin
      if (palette_valid && palette_ready) cur_palette = palette_prom_bytes;
      if (start && !busy) predict_request('{func, vram_offset, write_byte, select_bit_index});
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (req_q.size() > 0) begin
          next_req = req_q.pop_front();
          func <= next_req.op;
          vram_offset <= next_req.off;
          write_byte <= next_req.data;
          select_bit_index <= next_req.idx;
          start <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Monitor: results cannot be held off, one per strobe
  scan_result_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if ($isunknown(strobe)) begin
        $display("%0t: strobe unknown, expected 0 or 1, got %b", $time, strobe);
        errors++;
      end else if (strobe) begin
        if (scan_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got read_byte %h pixel_x %h",
                   $time, read_byte, pixel_x);
          errors++;
        end else begin
          want = scan_expect_q.pop_front();
          check_field("read_byte", want.read_byte, read_byte);
          check_field("pixel_x", want.pixel_x, pixel_x);
          check_field("pixel_y", want.pixel_y, pixel_y);
          check_field("color_index", 8'(want.color_index), 8'(color_index));
          check_field("red_on", 8'(want.red_on), 8'(red_on));
          check_field("green_on", 8'(want.green_on), 8'(green_on));
          check_field("blue_on", 8'(want.blue_on), 8'(blue_on));
          check_field("is_pixel", 8'(want.is_pixel), 8'(is_pixel));
          check_field("last_pixel", 8'(want.last_pixel), 8'(last_pixel));
        end
      end
    end
  end

  // Queue a request and track which plane bytes it makes readable
  task automatic queue_request(input func_t op, input int off, input int data, input int idx);
    vram_req_t rq;
    logic [2:0] was;
    rq.op   = op;
    rq.off  = off[OFF_W-1:0];
    rq.data = data[7:0];
    rq.idx  = idx[0];
    req_q.push_back(rq);
    if (op == FUNC_SELECT) begin
      gen_sel[rq.idx] = rq.data[0];
    end else if (op == FUNC_WRITE) begin
      was = wr_mark[rq.off];
      if (gen_sel == SEL_CLEAR) wr_mark[rq.off] = 3'b111;
      else wr_mark[rq.off][gen_sel] = 1'b1;
      if (was == 3'b000) wr_list.push_back(rq.off);
      if (was != 3'b111 && wr_mark[rq.off] == 3'b111) fetch_ok.push_back(rq.off);
    end
  endtask

  task automatic add_random_request();
    int pick;
    int off;
    int tries;
    bit found;
    pick = $urandom_range(0, 99);
    found = 1'b0;
    if (pick < 12) begin
      queue_request(FUNC_SELECT, $urandom_range(0, DEPTH - 1), $urandom_range(0, 255),
                    $urandom_range(0, 1));
      return;
    end
    if (pick < 42 && fetch_ok.size() > 0) begin
      queue_request(FUNC_FETCH, fetch_ok[$urandom_range(0, fetch_ok.size() - 1)],
                    $urandom_range(0, 255), $urandom_range(0, 1));
      return;
    end
    if (pick < 66) begin
      if (gen_sel == SEL_CLEAR) begin
        // cleared select reads as zero, no plane byte is involved
        off = $urandom_range(0, DEPTH - 1);
        found = 1'b1;
      end else begin
        for (tries = 0; tries < 8 && !found && wr_list.size() > 0; tries++) begin
          off = wr_list[$urandom_range(0, wr_list.size() - 1)];
          found = wr_mark[off][gen_sel];
        end
      end
      if (found) begin
        queue_request(FUNC_READ, off, $urandom_range(0, 255), $urandom_range(0, 1));
        return;
      end
    end
    off = $urandom_range(0, 1) ? hot_offs[$urandom_range(0, 15)] : $urandom_range(0, DEPTH - 1);
    queue_request(FUNC_WRITE, off, $urandom_range(0, 255), $urandom_range(0, 1));
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (req_q.size() != 0 || start || busy || scan_expect_q.size() != 0);
    // writes and select changes produce no result; let them retire
    repeat (20) @(posedge clk);
  endtask

  task automatic set_palette(input logic [PAL_W-1:0] value);
    @(posedge clk);
    palette_valid <= 1'b1;
    palette_prom_bytes <= value;
    do @(posedge clk);
    while (!palette_ready);
    palette_valid <= 1'b0;
  endtask

  initial begin
    int phase;
    int n;
    for (n = 0; n < DEPTH; n++) wr_mark[n] = 3'b000;
    hot_offs[0] = 0;
    hot_offs[1] = DEPTH - 1;
    hot_offs[2] = 13'h1FE0;
    hot_offs[3] = 31;
    for (n = 4; n < 16; n++) hot_offs[n] = $urandom_range(0, DEPTH - 1);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    set_palette({PAL_W{1'b1}});

    // Directed: offset extremes in every plane, select bits both ways, clear select
    queue_request(FUNC_SELECT, 0, 8'hFE, 0);
    queue_request(FUNC_WRITE, 0, 8'hFF, 0);
    queue_request(FUNC_WRITE, DEPTH - 1, 8'h00, 1);
    queue_request(FUNC_SELECT, 5, 8'h01, 0);
    queue_request(FUNC_WRITE, 0, 8'h0F, 0);
    queue_request(FUNC_WRITE, DEPTH - 1, 8'hAA, 0);
    queue_request(FUNC_SELECT, DEPTH - 1, 8'h03, 1);
    queue_request(FUNC_READ, 0, 8'h77, 0);
    queue_request(FUNC_SELECT, 0, 8'h00, 0);
    queue_request(FUNC_WRITE, 0, 8'h33, 1);
    queue_request(FUNC_WRITE, DEPTH - 1, 8'hFF, 0);
    queue_request(FUNC_READ, DEPTH - 1, 8'h00, 1);
    queue_request(FUNC_FETCH, 0, 8'hFF, 1);
    queue_request(FUNC_FETCH, DEPTH - 1, 8'h00, 0);
    queue_request(FUNC_SELECT, 0, 8'hFF, 0);
    queue_request(FUNC_WRITE, 0, 8'h5A, 0);
    queue_request(FUNC_FETCH, 0, 8'h00, 0);
    queue_request(FUNC_WRITE, 13'h1FE0, 8'hC3, 1);
    queue_request(FUNC_FETCH, 13'h1FE0, 8'h00, 1);
    queue_request(FUNC_READ, DEPTH - 1, 8'hFF, 0);
    queue_request(FUNC_SELECT, DEPTH - 1, 8'h80, 1);
    queue_request(FUNC_READ, DEPTH - 1, 8'h11, 1);
    queue_request(FUNC_READ, 0, 8'h22, 0);
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_palette('0);
        1: set_palette(64'h6424_4060_2404_6020);
        default: set_palette({$urandom, $urandom});
      endcase
      for (n = 0; n < 47; n++) add_random_request();
      wait_drained();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
